[rtl/ngc_pkg.sv]
// Package for the numeric grouping checker: request/response types,
// configuration and field-state structs, status codes and character constants.
// No dependencies.
package ngc_pkg;

  localparam int unsigned CharWidth       = 8;
  localparam int unsigned DistWidth       = 3;
  localparam int unsigned DecCountWidth   = 8;
  localparam int unsigned CountWidthDflt  = 8;
  localparam int unsigned CfgAddrWidth    = 3;
  localparam int unsigned CfgDataWidth    = 32;

  localparam logic [DistWidth-1:0] DistMax      = 3'd7;
  localparam logic [DistWidth-1:0] GroupSpan    = 3'd3;
  localparam logic [DistWidth-1:0] FirstGroupMax = 3'd3;

  localparam logic [CharWidth-1:0] CharDollar = 8'h24;
  localparam logic [CharWidth-1:0] CharMinus  = 8'h2D;
  localparam logic [CharWidth-1:0] CharPlus   = 8'h2B;
  localparam logic [CharWidth-1:0] CharSpace  = 8'h20;

  localparam logic [CharWidth-1:0] GroupSepReset   = 8'd44;
  localparam logic [CharWidth-1:0] DecimalSepReset = 8'd46;

  // Register index, taken from paddr[2]
  localparam logic RegGroupSep   = 1'b0;
  localparam logic RegDecimalSep = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_SEP_AFTER_DEC = 2'd1,
    STATUS_BAD_GROUP     = 2'd2
  } status_e;

  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 is_last;
  } ngc_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [DecCountWidth-1:0] decimal_count;
  } ngc_rsp_t;

  typedef struct packed {
    logic [CharWidth-1:0] group_sep;
    logic [CharWidth-1:0] decimal_sep;
  } ngc_cfg_t;

  typedef struct packed {
    logic                 in_prefix;
    logic                 seen_decimal;
    logic                 seen_group;
    logic [DistWidth-1:0] from_start;
    logic [DistWidth-1:0] from_group;
    status_e              error_code;
  } ngc_state_t;

  localparam ngc_state_t StateReset = '{
    in_prefix:    1'b1,
    seen_decimal: 1'b0,
    seen_group:   1'b0,
    from_start:   '0,
    from_group:   '0,
    error_code:   STATUS_OK
  };

  function automatic logic [DistWidth-1:0] dist_inc(input logic [DistWidth-1:0] d);
    return (d == DistMax) ? d : d + 3'd1;
  endfunction

endpackage

[rtl/ngc_cfg.sv]
// APB-style configuration registers for the numeric grouping checker.
// Depends on ngc_pkg.
module ngc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ngc_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [ngc_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [ngc_pkg::CfgDataWidth-1:0]  prdata,
  output logic                              pready,
  output ngc_pkg::ngc_cfg_t                 cfg_o
);
  import ngc_pkg::*;

  logic [CharWidth-1:0] group_sep_q, decimal_sep_q;
  logic                 wr_en;
  logic                 reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_sep_q   <= GroupSepReset;
      decimal_sep_q <= DecimalSepReset;
    end else if (wr_en) begin
      if (reg_idx == RegGroupSep) begin
        group_sep_q <= pwdata[CharWidth-1:0];
      end else begin
        decimal_sep_q <= pwdata[CharWidth-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegGroupSep:   prdata[CharWidth-1:0] = group_sep_q;
      RegDecimalSep: prdata[CharWidth-1:0] = decimal_sep_q;
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = '{group_sep: group_sep_q, decimal_sep: decimal_sep_q};

endmodule

[rtl/ngc_step.sv]
// Next-state logic for one character of a numeric field: prefix skip,
// separator distance checks, error freeze and decimal counting. Depends on ngc_pkg.
module ngc_step #(
  parameter int unsigned CountWidth = ngc_pkg::CountWidthDflt,
  localparam int unsigned DecW = (CountWidth >= 8) ? 8 : CountWidth
) (
  input  ngc_pkg::ngc_cfg_t   cfg_i,
  input  ngc_pkg::ngc_req_t   req_i,
  input  ngc_pkg::ngc_state_t st_i,
  input  logic [DecW-1:0]     dec_i,
  output ngc_pkg::ngc_state_t st_o,
  output logic [DecW-1:0]     dec_o
);
  import ngc_pkg::*;

  logic [CharWidth-1:0] c;
  logic                 is_grp, is_dec, group_now;

  assign c      = req_i.char_code;
  assign is_grp = (c == cfg_i.group_sep);
  assign is_dec = (c == cfg_i.decimal_sep);

  always_comb begin
    st_o      = st_i;
    dec_o     = dec_i;
    group_now = 1'b0;
    if (st_i.error_code == STATUS_OK &&
        !(st_i.in_prefix && (c inside {CharDollar, CharMinus, CharPlus}))) begin
      st_o.in_prefix = 1'b0;
      if (is_grp || is_dec) begin
        if (st_i.seen_decimal) begin
          st_o.error_code = STATUS_SEP_AFTER_DEC;
        end else if ((st_i.seen_group && st_i.from_group != GroupSpan) ||
                     (!st_i.seen_group && is_grp && st_i.from_start > FirstGroupMax)) begin
          st_o.error_code = STATUS_BAD_GROUP;
        end else if (is_dec) begin
          st_o.seen_decimal = 1'b1;
        end else begin
          st_o.seen_group = 1'b1;
          group_now       = 1'b1;
        end
      end else if (st_i.seen_decimal && c != CharSpace) begin
        if (dec_i != {DecW{1'b1}}) begin
          dec_o = dec_i + {{(DecW-1){1'b0}}, 1'b1};
        end
      end
      st_o.from_start = dist_inc(st_i.from_start);
      st_o.from_group = group_now ? '0 : dist_inc(st_i.from_group);
    end
  end

endmodule

[rtl/numeric_grouping_checker_unit.sv]
// Top level of the numeric grouping checker: input register, step logic,
// result register and APB configuration. Depends on ngc_pkg, ngc_cfg, ngc_step.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_req_i          | request in
//  out     | out_valid_o, out_ready_i, out_rsp_o       | result out
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | APB slave
//          | prdata, pready                            |
//
// One character request per cycle is accepted while no last character is held
// back. Each request is loaded into the input register, then the step logic
// updates the field state and, on the last character, loads the result register,
// which drives out_valid_o.
// Characters without is_last always move on; a last character
// waits only while the result register still holds an untaken result.
// Reset (rst_ni low, asynchronous) restores both separators and clears the
// field state; there is no clearing pass.
module numeric_grouping_checker_unit #(
  parameter int unsigned COUNT_WIDTH = ngc_pkg::CountWidthDflt
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ngc_pkg::ngc_req_t                 in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ngc_pkg::ngc_rsp_t                 out_rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ngc_pkg::CfgAddrWidth-1:0]  paddr,
  input  logic [ngc_pkg::CfgDataWidth-1:0]  pwdata,
  output logic [ngc_pkg::CfgDataWidth-1:0]  prdata,
  output logic                              pready
);
  import ngc_pkg::*;

  // Width of the decimal counter; it saturates at all ones.
  localparam int unsigned DecW = (COUNT_WIDTH >= 8) ? 8 : COUNT_WIDTH;

  ngc_cfg_t   cfg;
  logic       in_valid_q;
  ngc_req_t   in_q;
  ngc_state_t st_q, st_next, st_d;
  logic [DecW-1:0] dec_q, dec_next, dec_d;
  logic       out_valid_q, out_valid_d;
  ngc_rsp_t   out_q;
  logic       out_free, advance;

  ngc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ngc_step #(.CountWidth(COUNT_WIDTH)) u_step (
    .cfg_i (cfg),
    .req_i (in_q),
    .st_i  (st_q),
    .dec_i (dec_q),
    .st_o  (st_next),
    .dec_o (dec_next)
  );

  // Result register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  // Advance the held request unless it is a last character facing a full result.
  assign advance    = in_valid_q && (!in_q.is_last || out_free);
  assign in_ready_o = !in_valid_q || advance;

  // Field state: take the step result, drop back to reset after the last character.
  always_comb begin
    st_d  = st_q;
    dec_d = dec_q;
    if (advance) begin
      if (in_q.is_last) begin
        st_d  = StateReset;
        dec_d = '0;
      end else begin
        st_d  = st_next;
        dec_d = dec_next;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && in_q.is_last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      st_q        <= StateReset;
      dec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      st_q        <= st_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold until the next load.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
    if (advance && in_q.is_last) begin
      out_q.status        <= st_next.error_code;
      out_q.decimal_count <= DecCountWidth'(dec_next);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

[rtl/ngc_checker.sv]
// Port-level checks for numeric_grouping_checker_unit, with the bind that
// attaches them. Depends on ngc_pkg and numeric_grouping_checker_unit.
module ngc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input ngc_pkg::ngc_req_t                 in_req_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input ngc_pkg::ngc_rsp_t                 out_rsp_o,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [ngc_pkg::CfgAddrWidth-1:0]  paddr,
  input logic [ngc_pkg::CfgDataWidth-1:0]  pwdata,
  input logic [ngc_pkg::CfgDataWidth-1:0]  prdata,
  input logic                              pready
);
  import ngc_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // Input only backs up behind an untaken result.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a full result");

  // Status code 3 is never produced.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.status != 2'd3)
    else $error("invalid status code");

  // Configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("pready low during access");

endmodule

bind numeric_grouping_checker_unit ngc_checker u_ngc_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for numeric_grouping_checker_unit: streams numeric text
// fields through the request channel and checks each status/count result.
// Depends on ngc_pkg and the RTL of the checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ngc_pkg::*;

  localparam int unsigned CountCap     = 255;  // 2^COUNT_WIDTH-1 at the default width
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainLimit   = 2000;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  ngc_req_t                in_req_i    = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  ngc_rsp_t                out_rsp_o;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [CfgAddrWidth-1:0] paddr       = '0;
  logic [CfgDataWidth-1:0] pwdata      = '0;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  // Quiet stretches: neither side idles nor stalls.
  bit          quiet          = 1'b0;
  int unsigned fail_count     = 0;
  int unsigned fields_checked = 0;
  int unsigned chars_sent     = 0;
  int unsigned settings_done  = 0;

  // Expected field results, oldest first.
  ngc_rsp_t field_results[$];

  // Separator copies and field state mirrored from the block.
  logic [7:0] sep_group   = GroupSepReset;
  logic [7:0] sep_decimal = DecimalSepReset;
  logic       fld_prefix  = 1'b1;
  logic       fld_decimal = 1'b0;
  logic       fld_grouped = 1'b0;
  logic [2:0] fld_from_start = '0;
  logic [2:0] fld_from_group = '0;
  logic [7:0] fld_decimals   = '0;
  status_e    fld_status     = STATUS_OK;

  numeric_grouping_checker_unit dut (.*);

  always #10 clk_i = ~clk_i;

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("FAIL @%0t: %s", $realtime, msg);
  endfunction

  // Advance the mirrored field state by one accepted character; on the last
  // character queue the expected result and start a fresh field.
  function automatic void track_char(input ngc_req_t req);
    logic       grouped_now;
    logic [7:0] code;
    ngc_rsp_t   rsp;
    grouped_now = 1'b0;
    code        = req.char_code;
    // After an error every character just waits for the end of the field.
    if (fld_status == STATUS_OK &&
        !(fld_prefix && (code == CharDollar || code == CharMinus || code == CharPlus))) begin
      fld_prefix = 1'b0;
      if (code == sep_group || code == sep_decimal) begin
        if (fld_decimal) begin
          fld_status = STATUS_SEP_AFTER_DEC;
        end else if ((fld_grouped && fld_from_group != GroupSpan) ||
                     (!fld_grouped && code == sep_group && fld_from_start > FirstGroupMax)) begin
          fld_status = STATUS_BAD_GROUP;
        end else if (code == sep_decimal) begin
          // Same code for both separators lands here: decimal wins.
          fld_decimal = 1'b1;
        end else begin
          fld_grouped    = 1'b1;
          fld_from_group = '0;
          grouped_now    = 1'b1;
        end
      end else if (fld_decimal && code != CharSpace) begin
        if (fld_decimals != CountCap[7:0]) fld_decimals = fld_decimals + 8'd1;
      end
      if (fld_from_start != DistMax) fld_from_start = fld_from_start + 3'd1;
      if (!grouped_now && fld_from_group != DistMax) fld_from_group = fld_from_group + 3'd1;
    end
    if (req.is_last) begin
      rsp.status        = fld_status;
      rsp.decimal_count = fld_decimals;
      field_results.push_back(rsp);
      fld_prefix     = 1'b1;
      fld_decimal    = 1'b0;
      fld_grouped    = 1'b0;
      fld_from_start = '0;
      fld_from_group = '0;
      fld_decimals   = '0;
      fld_status     = STATUS_OK;
    end
  endfunction

  // Result side: compare at the accepting edge, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (field_results.size() == 0) begin
        note_failure($sformatf("result with no field pending: status %0d count %0d",
                               out_rsp_o.status, out_rsp_o.decimal_count));
      end else begin
        ngc_rsp_t want;
        want = field_results.pop_front();
        fields_checked++;
        if (want.status != out_rsp_o.status)
          note_failure($sformatf("status: expected %0d, got %0d",
                                 want.status, out_rsp_o.status));
        if (want.decimal_count != out_rsp_o.decimal_count)
          note_failure($sformatf("decimal_count: expected %0d, got %0d",
                                 want.decimal_count, out_rsp_o.decimal_count));
      end
    end
    out_ready_i <= quiet || ($urandom_range(99) >= 16);
  end

  // Send one character request; hold valid until accepted.
  task automatic send_char(input logic [7:0] code, input logic last);
    ngc_req_t req;
    req.char_code = code;
    req.is_last   = last;
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chars_sent++;
    track_char(req);
  endtask

  task automatic send_bytes(input logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_bytes(text);
  endtask

  // Drop valid, wait for every expected result, then let the pipe empty.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (field_results.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == RegGroupSep) sep_group = value;
    else sep_decimal = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== value)
      note_failure($sformatf("register %0d read: expected %0d, got %0d", idx, value,
                             prdata[7:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] prefix_char();
    case ($urandom_range(2))
      0:       return CharDollar;
      1:       return CharMinus;
      default: return CharPlus;
    endcase
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  // Build one field: mostly well-formed numbers with random content, some of
  // them broken by a bad group or a stray separator, the rest raw noise.
  task automatic send_field();
    logic [7:0]  text[$];
    int unsigned groups;
    int unsigned n;
    if ($urandom_range(99) < 75) begin
      repeat ($urandom_range(0, 2)) text.push_back(prefix_char());
      groups = $urandom_range(0, 3);
      repeat (groups != 0 ? $urandom_range(1, 3) : $urandom_range(1, 5))
        text.push_back(digit_char());
      repeat (groups) begin
        text.push_back(sep_group);
        n = ($urandom_range(9) == 0) ? $urandom_range(2, 4) : 3;
        repeat (n) text.push_back(digit_char());
      end
      if ($urandom_range(1) != 0) begin
        text.push_back(sep_decimal);
        repeat ($urandom_range(0, 6))
          text.push_back(($urandom_range(7) == 0) ? CharSpace : digit_char());
      end
      if ($urandom_range(4) == 0)
        text.push_back($urandom_range(1) != 0 ? sep_group : sep_decimal);
      if ($urandom_range(3) == 0) text.push_back(CharSpace);
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(7))
          0:       text.push_back(sep_group);
          1:       text.push_back(sep_decimal);
          2:       text.push_back(prefix_char());
          3:       text.push_back(CharSpace);
          default: text.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    send_bytes(text);
  endtask

  // Extremes, each status, prefix-only field and the frozen error count.
  task automatic test_directed();
    send_text("1,234.5");
    send_text("-$");
    send_text("1234,");
    send_text(".5.6");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    settle();
  endtask

  // A fraction long enough to drive the decimal count into saturation.
  task automatic test_decimal_saturation();
    send_char(digit_char(), 1'b0);
    send_char(sep_decimal, 1'b0);
    repeat (CountCap + 2) send_char(digit_char(), 1'b0);
    send_char(digit_char(), 1'b1);
    settle();
  endtask

  task automatic test_random_fields(input int unsigned budget, input bit with_quiet);
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < budget) begin
      quiet = with_quiet && (chars_sent - start < budget / 2);
      send_field();
    end
    quiet = 1'b0;
    settle();
  endtask

  // Walk through separator settings: extremes, shared code, space separators.
  task automatic test_separator_settings();
    logic [7:0] group_codes[6];
    logic [7:0] decimal_codes[6];
    group_codes   = '{8'h00, 8'hFF, CharSpace, GroupSepReset, 8'h00, GroupSepReset};
    decimal_codes = '{8'hFF, 8'h00, CharSpace, CharSpace, 8'h00, DecimalSepReset};
    group_codes[4]   = 8'($urandom_range(255));
    decimal_codes[4] = 8'($urandom_range(255));
    for (int i = 0; i < 6; i++) begin
      write_reg(RegGroupSep, group_codes[i]);
      write_reg(RegDecimalSep, decimal_codes[i]);
      settings_done++;
      @(posedge clk_i);
      test_random_fields(40, 1'b0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_decimal_saturation();
    test_random_fields(200, 1'b1);
    test_separator_settings();
    settle();
    if (field_results.size() != 0) begin
      note_failure($sformatf("%0d field results never arrived", field_results.size()));
    end
    $display("Checked %0d field results from %0d characters over %0d separator settings",
             fields_checked, chars_sent, settings_done + 1);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ngc_pkg.sv
rtl/ngc_cfg.sv
rtl/ngc_step.sv
rtl/numeric_grouping_checker_unit.sv
rtl/ngc_checker.sv
tb/testbench.sv
